[sv/nir_pkg.sv]
// nir_pkg: shared types and constants of the nec infrared pulse decoder
`default_nettype none

package nir_pkg;

   localparam int INTERVAL_W = 24;
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int QUEUE_DEPTH = 4;

   // item opcodes
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_END  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_MIN       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_MAX       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_MIN        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_MAX        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_CODE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION_CODE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_CODE  = 3'd6;

   typedef struct packed {
      logic [INTERVAL_W-1:0] zero_min;
      logic [INTERVAL_W-1:0] zero_max;
      logic [INTERVAL_W-1:0] one_min;
      logic [INTERVAL_W-1:0] one_max;
   } win_cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] speed;
      logic [BYTE_W-1:0] direction;
      logic [BYTE_W-1:0] distance;
   } code_cfg_type;

   typedef enum logic [1:0] {
      CLS_ZERO,
      CLS_ONE,
      CLS_NONE
   } cls_type;

   typedef enum logic [1:0] {
      KIND_CMD,
      KIND_DATA,
      KIND_END
   } kind_type;

   // one classified operation handed from the front to the back
   typedef struct packed {
      kind_type   kind;
      cls_type    cls;
      logic [2:0] bit_idx;
   } entry_type;

endpackage

`default_nettype wire

[sv/nir_req_if.sv]
// nir_req_if: input channel carrying edge and timeout beats
`default_nettype none

interface nir_req_if;
   logic                           valid;
   logic                           ready;
   logic                           op;
   logic [nir_pkg::INTERVAL_W-1:0] interval;

   modport source (output valid, output op, output interval, input ready);
   modport sink   (input valid, input op, input interval, output ready);
endinterface

`default_nettype wire

[sv/nir_rsp_if.sv]
// nir_rsp_if: result channel carrying one beat per frame end
`default_nettype none

interface nir_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [nir_pkg::BYTE_W-1:0] command;
   logic [nir_pkg::BYTE_W-1:0] payload;
   logic                       payload_updated;

   modport source (output valid, output command, output payload, output payload_updated,
                   input ready);
   modport sink   (input valid, input command, input payload, input payload_updated,
                   output ready);
endinterface

`default_nettype wire

[sv/nir_front.sv]
// nir_front: frame tracking and interval classification
`default_nettype none

module nir_front #(
   parameter int FRAME_SLOTS = 50
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire nir_pkg::win_cfg_type win_cfg,
   nir_req_if.sink                   req_if,
   output logic                      push_valid,
   output nir_pkg::entry_type        push_entry,
   input  wire logic                 push_ready
);
   import nir_pkg::*;

   localparam int SLOT_W = $clog2(FRAME_SLOTS);

   logic              in_frame_ff, in_frame_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              accept;
   cls_type           cls;

   assign req_if.ready = push_ready;
   assign accept       = req_if.valid && push_ready;

   // zero window wins where the windows overlap
   always_comb begin
      if (req_if.interval >= win_cfg.zero_min && req_if.interval <= win_cfg.zero_max) begin
         cls = CLS_ZERO;
      end else if (req_if.interval >= win_cfg.one_min &&
                   req_if.interval <= win_cfg.one_max) begin
         cls = CLS_ONE;
      end else begin
         cls = CLS_NONE;
      end
   end

   always_comb begin
      in_frame_in        = in_frame_ff;
      slot_in            = slot_ff;
      push_valid         = 1'b0;
      push_entry.kind    = KIND_END;
      push_entry.cls     = cls;
      push_entry.bit_idx = '0;
      if (accept) begin
         if (req_if.op == OP_END) begin
            in_frame_in     = 1'b0;
            slot_in         = '0;
            push_valid      = 1'b1;
            push_entry.kind = KIND_END;
         end else if (!in_frame_ff) begin
            in_frame_in = 1'b1;
         end else begin
            if (slot_ff >= SLOT_W'(1) && slot_ff <= SLOT_W'(8)) begin
               push_valid         = 1'b1;
               push_entry.kind    = KIND_CMD;
               push_entry.bit_idx = 3'(SLOT_W'(8) - slot_ff);
            end else if (slot_ff >= SLOT_W'(17) && slot_ff <= SLOT_W'(24)) begin
               push_valid         = 1'b1;
               push_entry.kind    = KIND_DATA;
               push_entry.bit_idx = 3'(SLOT_W'(24) - slot_ff);
            end
            // saturate at the last slot
            if (slot_ff < SLOT_W'(FRAME_SLOTS - 1)) begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         slot_ff     <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         slot_ff     <= slot_in;
      end
   end

endmodule

`default_nettype wire

[sv/nir_queue.sv]
// nir_queue: short fifo of classified operations between front and back
`default_nettype none

module nir_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire nir_pkg::entry_type push_entry,
   output logic                    push_ready,
   output logic                    pop_valid,
   output nir_pkg::entry_type      pop_entry,
   input  wire logic               pop_ready
);
   import nir_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

[sv/nir_back.sv]
// nir_back: command and data byte update and result register
`default_nettype none

module nir_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire nir_pkg::code_cfg_type code_cfg,
   input  wire logic                  pop_valid,
   input  wire nir_pkg::entry_type    pop_entry,
   output logic                       pop_ready,
   nir_rsp_if.source                  rsp_if
);
   import nir_pkg::*;

   logic [BYTE_W-1:0] command_ff, command_in;
   logic [BYTE_W-1:0] payload_ff, payload_in;
   logic [BYTE_W-1:0] pend_value_ff, pend_value_in;
   logic [BYTE_W-1:0] pend_known_ff, pend_known_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_command_ff, rsp_command_in;
   logic [BYTE_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic              rsp_updated_ff, rsp_updated_in;
   logic              slot_free, do_pop, hit;
   logic [BYTE_W-1:0] mask;

   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign pop_ready = (pop_entry.kind != KIND_END) || slot_free;
   assign do_pop    = pop_valid && pop_ready;
   assign mask      = BYTE_W'(1) << pop_entry.bit_idx;
   assign hit       = (command_ff == code_cfg.speed) ||
                      (command_ff == code_cfg.direction) ||
                      (command_ff == code_cfg.distance);

   always_comb begin
      command_in     = command_ff;
      payload_in     = payload_ff;
      pend_value_in  = pend_value_ff;
      pend_known_in  = pend_known_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_command_in = rsp_command_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_updated_in = rsp_updated_ff;
      if (do_pop) begin
         unique case (pop_entry.kind)
            KIND_CMD: begin
               if (pop_entry.cls == CLS_ZERO) begin
                  command_in = command_ff & ~mask;
               end else if (pop_entry.cls == CLS_ONE) begin
                  command_in = command_ff | mask;
               end
            end
            KIND_DATA: begin
               if (pop_entry.cls == CLS_NONE) begin
                  pend_known_in = pend_known_ff & ~mask;
               end else begin
                  pend_known_in = pend_known_ff | mask;
                  if (pop_entry.cls == CLS_ONE) begin
                     pend_value_in = pend_value_ff | mask;
                  end else begin
                     pend_value_in = pend_value_ff & ~mask;
                  end
               end
            end
            KIND_END: begin
               if (hit) begin
                  payload_in = (payload_ff & ~pend_known_ff) |
                               (pend_value_ff & pend_known_ff);
               end
               rsp_valid_in   = 1'b1;
               rsp_command_in = command_ff;
               rsp_payload_in = payload_in;
               rsp_updated_in = hit;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff    <= '0;
         payload_ff    <= '0;
         pend_value_ff <= '0;
         pend_known_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         command_ff    <= command_in;
         payload_ff    <= payload_in;
         pend_value_ff <= pend_value_in;
         pend_known_ff <= pend_known_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_command_ff <= rsp_command_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_updated_ff <= rsp_updated_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.command         = rsp_command_ff;
   assign rsp_if.payload         = rsp_payload_ff;
   assign rsp_if.payload_updated = rsp_updated_ff;

endmodule

`default_nettype wire

[sv/nec_ir_pulse_decoder.sv]
// nec_ir_pulse_decoder: top level of the nec infrared pulse-distance decoder
//
//   channel  dir  beat contents                        handshake
//   req_if   in   op, interval[23:0]                   valid/ready
//   rsp_if   out  command[7:0], payload[7:0], updated  valid/ready
//   csr_*    in   csr_index[2:0], csr_wdata[23:0]      csr_we, no wait
//
// one request beat per cycle is accepted while the queue has room; an edge beat
// never makes a result; classification is combinational in the front, so a
// timeout beat's result beat is offered once the entry has passed through a
// queue slot and the back output register
// the four-entry queue sets the slack: req_if.ready drops only while it is full
// a stalled rsp_if holds only timeout entries at the queue head, edge entries
// keep draining; synchronous active-high reset, no clearing pass
`default_nettype none

module nec_ir_pulse_decoder #(
   parameter int FRAME_SLOTS = 50
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   nir_req_if.sink                              req_if,
   nir_rsp_if.source                            rsp_if,
   input  wire logic                            csr_we,
   input  wire logic [nir_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [nir_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import nir_pkg::*;

   // configuration registers
   win_cfg_type  win_cfg_ff;
   code_cfg_type code_cfg_ff;

   // front to queue and queue to back
   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   // register writes; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         win_cfg_ff.zero_min   <= INTERVAL_W'(1000);
         win_cfg_ff.zero_max   <= INTERVAL_W'(1300);
         win_cfg_ff.one_min    <= INTERVAL_W'(2000);
         win_cfg_ff.one_max    <= INTERVAL_W'(2500);
         code_cfg_ff.speed     <= BYTE_W'(0);
         code_cfg_ff.direction <= BYTE_W'(1);
         code_cfg_ff.distance  <= BYTE_W'(2);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ZERO_MIN:       win_cfg_ff.zero_min   <= csr_wdata;
            CSR_ZERO_MAX:       win_cfg_ff.zero_max   <= csr_wdata;
            CSR_ONE_MIN:        win_cfg_ff.one_min    <= csr_wdata;
            CSR_ONE_MAX:        win_cfg_ff.one_max    <= csr_wdata;
            CSR_SPEED_CODE:     code_cfg_ff.speed     <= csr_wdata[BYTE_W-1:0];
            CSR_DIRECTION_CODE: code_cfg_ff.direction <= csr_wdata[BYTE_W-1:0];
            CSR_DISTANCE_CODE:  code_cfg_ff.distance  <= csr_wdata[BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // front: tracks the open frame and slot, classifies each interval
   nir_front #(
      .FRAME_SLOTS (FRAME_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .win_cfg    (win_cfg_ff),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // decouples the two sides
   nir_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   // back: applies bits, matches codes at frame end, drives results
   nir_back u_back (
      .clock     (clock),
      .reset     (reset),
      .code_cfg  (code_cfg_ff),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire

[sim/tb_nec_ir_pulse_decoder.sv]
// testbench for the nec infrared pulse decoder: random frames checked against a frame predictor
`timescale 1ns / 100ps

module tb_nec_ir_pulse_decoder;
   import nir_pkg::*;

   localparam int FRAME_SLOTS   = 50;
   localparam int TARGET_BEATS  = 1370;
   localparam int HOLD_CYCLES   = 400;      // long receiver hold-off, fills the queue
   localparam int SETTLE_CYCLES = 16;       // edge entries still draining after last result
   localparam int LIMIT_NS      = 2000000;  // far beyond the slowest run

   // index past the last register, the block must ignore writes to it
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] payload;
      logic              payload_updated;
   } frame_result_type;

   // tracks the decoder state beat by beat and holds the results each frame end owes
   class nec_frame_tracker;
      logic [INTERVAL_W-1:0] zero_min, zero_max, one_min, one_max;
      logic [BYTE_W-1:0]     speed_code, direction_code, distance_code;
      logic                  in_frame;
      int unsigned           slot_idx;
      logic [BYTE_W-1:0]     command_q, payload_q, data_bits, data_known;
      frame_result_type      frame_results_due[$];
      int                    error_count;

      function new();
         zero_min       = 24'd1000;
         zero_max       = 24'd1300;
         one_min        = 24'd2000;
         one_max        = 24'd2500;
         speed_code     = 8'd0;
         direction_code = 8'd1;
         distance_code  = 8'd2;
         in_frame       = 1'b0;
         slot_idx       = 0;
         command_q      = '0;
         payload_q      = '0;
         data_bits      = '0;
         data_known     = '0;
         error_count    = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ZERO_MIN:       zero_min       = data;
            CSR_ZERO_MAX:       zero_max       = data;
            CSR_ONE_MIN:        one_min        = data;
            CSR_ONE_MAX:        one_max        = data;
            CSR_SPEED_CODE:     speed_code     = data[BYTE_W-1:0];
            CSR_DIRECTION_CODE: direction_code = data[BYTE_W-1:0];
            CSR_DISTANCE_CODE:  distance_code  = data[BYTE_W-1:0];
            default: ;
         endcase
      endfunction

      // zero window wins where the two windows overlap
      function cls_type classify(input logic [INTERVAL_W-1:0] t);
         if (t >= zero_min && t <= zero_max) return CLS_ZERO;
         if (t >= one_min && t <= one_max) return CLS_ONE;
         return CLS_NONE;
      endfunction

      function void note_beat(input logic op, input logic [INTERVAL_W-1:0] t);
         cls_type           c;
         logic [BYTE_W-1:0] m;
         logic              hit;
         frame_result_type  r;
         if (op == OP_EDGE) begin
            // first edge of a frame only opens it
            if (!in_frame) begin
               in_frame = 1'b1;
               return;
            end
            c = classify(t);
            if (slot_idx >= 1 && slot_idx <= 8) begin
               m = 8'd1 << (8 - slot_idx);
               if (c == CLS_ZERO) command_q = command_q & ~m;
               else if (c == CLS_ONE) command_q = command_q | m;
            end else if (slot_idx >= 17 && slot_idx <= 24) begin
               m = 8'd1 << (24 - slot_idx);
               if (c == CLS_NONE) begin
                  data_known = data_known & ~m;
               end else begin
                  data_known = data_known | m;
                  if (c == CLS_ONE) data_bits = data_bits | m;
                  else data_bits = data_bits & ~m;
               end
            end
            if (slot_idx < FRAME_SLOTS - 1) slot_idx++;
         end else begin
            hit = (command_q == speed_code) || (command_q == direction_code) ||
                  (command_q == distance_code);
            in_frame = 1'b0;
            slot_idx = 0;
            if (hit) payload_q = (payload_q & ~data_known) | (data_bits & data_known);
            r.command         = command_q;
            r.payload         = payload_q;
            r.payload_updated = hit;
            frame_results_due.push_back(r);
         end
      endfunction

      function void check_result(input logic [BYTE_W-1:0] command,
                                 input logic [BYTE_W-1:0] payload,
                                 input logic updated);
         frame_result_type want;
         if (frame_results_due.size() == 0) begin
            $error("result beat with none due: command %0h payload %0h payload_updated %0b",
                   command, payload, updated);
            error_count++;
            return;
         end
         want = frame_results_due.pop_front();
         if (command !== want.command) begin
            $error("command: expected %0h, actual %0h", want.command, command);
            error_count++;
         end
         if (payload !== want.payload) begin
            $error("payload: expected %0h, actual %0h", want.payload, payload);
            error_count++;
         end
         if (updated !== want.payload_updated) begin
            $error("payload_updated: expected %0b, actual %0b", want.payload_updated, updated);
            error_count++;
         end
      endfunction

      function int frames_outstanding();
         return frame_results_due.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   nir_req_if req_if ();
   nir_rsp_if rsp_if ();

   nec_ir_pulse_decoder #(.FRAME_SLOTS(FRAME_SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   nec_frame_tracker tracker;
   int               beats_sent;
   int               burst_left;
   logic             rsp_holdoff_pending;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake or a lost result ends up here
   initial begin
      #(LIMIT_NS);
      $display("** nec_ir_pulse_decoder: FAILED **");
      $finish;
   end

   // monitor: every accepted beat is predicted, every result beat is checked
   // note comes before check so a same-edge result still finds its expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) tracker.note_beat(req_if.op, req_if.interval);
         if (rsp_if.valid && rsp_if.ready)
            tracker.check_result(rsp_if.command, rsp_if.payload, rsp_if.payload_updated);
      end
   end

   // receiver: its own stall pattern, cycling through its modes in turn,
   // plus one long hold-off on request from the stimulus
   initial begin : rsp_stall_pattern
      int unsigned cyc;
      int unsigned mode;
      rsp_if.ready = 1'b0;
      cyc = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (rsp_holdoff_pending) begin
            rsp_holdoff_pending = 1'b0;
            rsp_if.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         mode = (cyc / 200) % 4;
         case (mode)
            0: rsp_if.ready = 1'b1;                  // no stalls at all
            1: rsp_if.ready = 1'($urandom % 2);
            2: rsp_if.ready = ($urandom % 4) == 0;   // mostly stalled
            default: rsp_if.ready = (cyc % 7) < 3;   // fixed duty pattern
         endcase
      end
   end

   // one beat on the input channel, returns at the edge it is accepted
   task automatic send_beat(input logic op, input logic [INTERVAL_W-1:0] iv);
      @(negedge clock);
      req_if.valid    = 1'b1;
      req_if.op       = op;
      req_if.interval = iv;
      beats_sent++;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // sender works in bursts; a gap follows each burst, long bursts give idle-free stretches
   task automatic push_beat(input logic op, input logic [INTERVAL_W-1:0] iv);
      int gap;
      send_beat(op, iv);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom % 8 == 0) ? $urandom_range(60, 30) : $urandom_range(12, 1);
         gap = $urandom_range(6, 1);
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // pause the sender until every frame result is back, then let the queue settle
   task automatic drain_frames();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (tracker.frames_outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // want: 0 zero window, 1 one window, 2 anything, 3 just outside a window edge
   function automatic logic [INTERVAL_W-1:0] pick_interval(input int want);
      logic [INTERVAL_W-1:0] lo, hi;
      lo = (want == 1) ? tracker.one_min : tracker.zero_min;
      hi = (want == 1) ? tracker.one_max : tracker.zero_max;
      if (want == 3) begin
         case ($urandom % 4)
            0: return tracker.zero_min - 1'b1;
            1: return tracker.zero_max + 1'b1;
            2: return tracker.one_min - 1'b1;
            default: return tracker.one_max + 1'b1;
         endcase
      end
      // an empty window cannot be hit, so fall back to anything
      if (want == 2 || lo > hi) return INTERVAL_W'($urandom);
      case ($urandom % 4)
         0: return lo;
         1: return hi;
         default: return INTERVAL_W'($urandom_range(hi, lo));
      endcase
   endfunction

   // a bit interval, now and then spoiled so the slot stays unclassified
   function automatic logic [INTERVAL_W-1:0] bit_interval(input logic b);
      int r;
      r = $urandom % 16;
      if (r == 0) return pick_interval(2);
      if (r == 1) return pick_interval(3);
      return pick_interval(b ? 1 : 0);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_command();
      case ($urandom % 6)
         0: return tracker.speed_code;
         1: return tracker.direction_code;
         2: return tracker.distance_code;
         default: return BYTE_W'($urandom);
      endcase
   endfunction

   // opening edge, n_slots stored intervals, then the timeout
   task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                             input int n_slots);
      logic [INTERVAL_W-1:0] iv;
      push_beat(OP_EDGE, INTERVAL_W'($urandom));
      for (int s = 0; s < n_slots; s++) begin
         if (s == 0) iv = pick_interval(2);                   // leader
         else if (s <= 8) iv = bit_interval(cmd[8 - s]);
         else if (s <= 16) iv = pick_interval($urandom % 4);  // address bytes, not decoded
         else if (s <= 24) iv = bit_interval(data[24 - s]);
         else iv = pick_interval($urandom % 4);               // past the data, saturates later
         push_beat(OP_EDGE, iv);
      end
      push_beat(OP_END, INTERVAL_W'($urandom));
   endtask

   // every register written; codes carry junk in the upper data bits
   task automatic configure_phase(input int variant);
      logic [INTERVAL_W-1:0] zmin, zmax, omin, omax;
      logic [BYTE_W-1:0]     c0, c1, c2;
      c0 = BYTE_W'($urandom);
      c1 = BYTE_W'($urandom);
      c2 = BYTE_W'($urandom);
      case (variant)
         0: begin  // well-separated windows near the usual timing
            zmin = INTERVAL_W'($urandom_range(1500, 500));
            zmax = zmin + INTERVAL_W'($urandom_range(500, 0));
            omin = zmax + INTERVAL_W'($urandom_range(1000, 1));
            omax = omin + INTERVAL_W'($urandom_range(800, 0));
         end
         1: begin  // both windows cover everything, zero wins
            zmin = '0;
            zmax = '1;
            omin = '0;
            omax = '1;
            c0 = 8'hFF;
            c1 = 8'h00;
            c2 = 8'hFF;
         end
         2: begin  // empty zero window, one window covers everything
            zmin = '1;
            zmax = '0;
            omin = '0;
            omax = '1;
            c0 = 8'h00;
            c1 = 8'h00;
            c2 = 8'h00;
         end
         3: begin  // overlapping windows, 2500 lies in both
            zmin = INTERVAL_W'($urandom_range(1500, 0));
            zmax = INTERVAL_W'($urandom_range(6000, 3000));
            omin = INTERVAL_W'($urandom_range(2500, 1600));
            omax = INTERVAL_W'($urandom_range(24'hFFFFFF, 4000));
         end
         default: begin  // anything, including empty windows
            zmin = INTERVAL_W'($urandom);
            zmax = INTERVAL_W'($urandom);
            omin = INTERVAL_W'($urandom);
            omax = INTERVAL_W'($urandom);
         end
      endcase
      write_csr(CSR_ZERO_MIN, zmin);
      write_csr(CSR_ZERO_MAX, zmax);
      write_csr(CSR_ONE_MIN, omin);
      write_csr(CSR_ONE_MAX, omax);
      write_csr(CSR_SPEED_CODE, {16'($urandom), c0});
      write_csr(CSR_DIRECTION_CODE, {16'($urandom), c1});
      write_csr(CSR_DISTANCE_CODE, {16'($urandom), c2});
      // out-of-range index must leave everything untouched
      write_csr(CSR_UNMAPPED, CSR_DATA_W'($urandom));
   endtask

   initial begin : stimulus
      int phase;
      int units;
      int n;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_if.valid        = 1'b0;
      req_if.op           = OP_EDGE;
      req_if.interval     = '0;
      rsp_holdoff_pending = 1'b0;
      beats_sent          = 0;
      burst_left          = $urandom_range(12, 1);
      tracker             = new();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset windows: timeout while idle, then a frame opened and closed at once
      push_beat(OP_END, 24'hFFFFFF);
      push_beat(OP_EDGE, 24'h000000);
      push_beat(OP_END, 24'h000000);

      // command bits on the window edges, just outside them, and at the field extremes
      push_beat(OP_EDGE, 24'hABCDEF);
      push_beat(OP_EDGE, 24'd9000);
      push_beat(OP_EDGE, 24'd1000);
      push_beat(OP_EDGE, 24'd1300);
      push_beat(OP_EDGE, 24'd2000);
      push_beat(OP_EDGE, 24'd2500);
      push_beat(OP_EDGE, 24'd999);
      push_beat(OP_EDGE, 24'd2501);
      push_beat(OP_EDGE, 24'd0);
      push_beat(OP_EDGE, 24'hFFFFFF);
      push_beat(OP_END, 24'h5A5A5A);
      drain_frames();

      // overlapping windows: an interval in both must clear a set command bit
      configure_phase(3);
      push_beat(OP_EDGE, 24'h123456);
      push_beat(OP_EDGE, 24'd9000);
      push_beat(OP_EDGE, 24'd2500);
      push_beat(OP_EDGE, 24'd2500);
      push_beat(OP_EDGE, 24'd2500);
      push_beat(OP_END, 24'd0);
      drain_frames();

      // random phases, each under its own register setting
      phase = 0;
      while (beats_sent < TARGET_BEATS) begin
         configure_phase(phase % 5);
         if (phase == 2) begin
            // hold the receiver off and keep offering timeouts until the input stalls
            rsp_holdoff_pending = 1'b1;
            repeat (12) send_beat(OP_END, INTERVAL_W'($urandom));
         end
         units = $urandom_range(8, 4);
         for (int u = 0; u < units; u++) begin
            case ($urandom % 10)
               7: send_frame(pick_command(), BYTE_W'($urandom),
                             $urandom_range(24, 0));                    // short frame
               8: send_frame(pick_command(), BYTE_W'($urandom),
                             $urandom_range(60, 26));                   // long frame, some reach slot overflow
               9: begin  // noise: loose edges and timeouts
                  n = $urandom_range(4, 1);
                  repeat (n) push_beat(($urandom % 3 == 0) ? OP_END : OP_EDGE,
                                       INTERVAL_W'($urandom));
               end
               default: send_frame(pick_command(), BYTE_W'($urandom),
                                   $urandom_range(26, 25));
            endcase
         end
         drain_frames();
         phase++;
      end

      if (tracker.error_count == 0) begin
         $display("** nec_ir_pulse_decoder: PASSED **");
      end else begin
         $display("** nec_ir_pulse_decoder: FAILED **");
      end
      $finish;
   end

endmodule
